// ===== sv/gsn_pkg.sv =====
package gsn_pkg;

    // fraction bits of the normal components
    localparam int FRAC_BITS = 14;

    localparam int IN_W   = 16;
    localparam int DIFF_W = IN_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NRM_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int OUT_W  = 16;
    localparam int LANES  = 3;

    localparam logic [31:0] OUT_POS_MAX = 32'd32767;
    localparam logic [31:0] OUT_NEG_MAX = 32'd32768;

    // word moving through the square-root cells
    typedef struct packed {
        logic [SQ_W-1:0]               rad;
        logic [REM_W-1:0]              rem;
        logic [ROOT_W-1:0]             root;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][MAG_W-1:0]   mag;
        logic                          degen;
    } sqrt_word_t;

    // word moving through the divider cells
    typedef struct packed {
        logic [ROOT_W-1:0]             len;
        logic [LANES-1:0][MAG_W-1:0]   rem;
        logic [LANES-1:0][Q_W-1:0]     low;
        logic [LANES-1:0][Q_W-1:0]     quo;
        logic [LANES-1:0]              neg;
        logic                          degen;
    } div_word_t;

endpackage

// ===== sv/gsn_front.sv =====
module gsn_front
    import gsn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [IN_W-1:0]  base_x,
    input  logic signed [IN_W-1:0]  base_y,
    input  logic signed [IN_W-1:0]  base_z,
    input  logic signed [IN_W-1:0]  row_next_x,
    input  logic signed [IN_W-1:0]  row_next_y,
    input  logic signed [IN_W-1:0]  row_next_z,
    input  logic signed [IN_W-1:0]  col_next_x,
    input  logic signed [IN_W-1:0]  col_next_y,
    input  logic signed [IN_W-1:0]  col_next_z,
    output logic                    out_valid,
    output sqrt_word_t              out_word
);

    logic signed [DIFF_W-1:0] ix, iy, iz, jx, jy, jz;
    logic signed [PROD_W-1:0] prod_next [6];
    logic signed [PROD_W-1:0] prod_reg  [6];
    logic signed [NRM_W-1:0]  nrm [LANES];
    logic [LANES-1:0]             neg_next, neg2_reg, neg3_reg;
    logic [LANES-1:0][MAG_W-1:0]  mag_next, mag2_reg, mag3_reg;
    logic [LANES-1:0][SQ_W-1:0]   sq_next, sq_reg;
    logic [3:0]                   valid_reg;
    sqrt_word_t                   word_next, word_reg;

    // stage 1: tangents and cross-product terms
    always_comb
    begin
        ix = {row_next_x[IN_W-1], row_next_x} - {base_x[IN_W-1], base_x};
        iy = {row_next_y[IN_W-1], row_next_y} - {base_y[IN_W-1], base_y};
        iz = {row_next_z[IN_W-1], row_next_z} - {base_z[IN_W-1], base_z};
        jx = {col_next_x[IN_W-1], col_next_x} - {base_x[IN_W-1], base_x};
        jy = {col_next_y[IN_W-1], col_next_y} - {base_y[IN_W-1], base_y};
        jz = {col_next_z[IN_W-1], col_next_z} - {base_z[IN_W-1], base_z};
        prod_next[0] = iy * jz;
        prod_next[1] = iz * jy;
        prod_next[2] = iz * jx;
        prod_next[3] = ix * jz;
        prod_next[4] = ix * jy;
        prod_next[5] = iy * jx;
    end

    // stage 2: normal components as sign and magnitude
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            nrm[k] = NRM_W'(prod_reg[2*k]) - NRM_W'(prod_reg[2*k+1]);
            neg_next[k] = nrm[k][NRM_W-1];
            mag_next[k] = neg_next[k] ? MAG_W'(-nrm[k]) : MAG_W'(nrm[k]);
        end
    end

    // stage 3: squares
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sq_next[k] = SQ_W'(mag2_reg[k]) * SQ_W'(mag2_reg[k]);
        end
    end

    // stage 4: squared length
    always_comb
    begin
        word_next       = '0;
        word_next.rad   = sq_reg[0] + sq_reg[1] + sq_reg[2];
        word_next.neg   = neg3_reg;
        word_next.mag   = mag3_reg;
        word_next.degen = (mag3_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            neg2_reg <= neg_next;
            mag2_reg <= mag_next;
            sq_reg   <= sq_next;
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_word  = word_reg;

endmodule

// ===== sv/gsn_sqrt_cell.sv =====
module gsn_sqrt_cell
    import gsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  sqrt_word_t  in_word,
    output logic        out_valid,
    output sqrt_word_t  out_word
);

    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;
    sqrt_word_t       word_next, word_reg;
    logic             valid_reg;

    // one root bit: bring down two radicand bits, try (root*4 + 1)
    always_comb
    begin
        rem_sh = {in_word.rem[REM_W-3:0], in_word.rad[SQ_W-1:SQ_W-2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, in_word.root, 2'b01};
        ge     = (rem_sh >= trial);
        word_next      = in_word;
        word_next.rad  = {in_word.rad[SQ_W-3:0], 2'b00};
        word_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        word_next.root = {in_word.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== sv/gsn_div_cell.sv =====
module gsn_div_cell
    import gsn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  div_word_t  in_word,
    output logic       out_valid,
    output div_word_t  out_word
);

    logic [MAG_W:0]   rem_sh [LANES];
    logic [MAG_W:0]   len_x;
    logic [LANES-1:0] ge;
    div_word_t        word_next, word_reg;
    logic             valid_reg;

    // one quotient bit per lane, restoring step
    always_comb
    begin
        len_x     = {1'b0, in_word.len};
        word_next = in_word;
        for (int k = 0; k < LANES; k++)
        begin
            rem_sh[k] = {in_word.rem[k], in_word.low[k][Q_W-1]};
            ge[k]     = (rem_sh[k] >= len_x);
            word_next.rem[k] = ge[k] ? MAG_W'(rem_sh[k] - len_x) : MAG_W'(rem_sh[k]);
            word_next.low[k] = {in_word.low[k][Q_W-2:0], 1'b0};
            word_next.quo[k] = {in_word.quo[k][Q_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== sv/grid_surface_normal.sv =====
// grid_surface_normal: unit normal of one mesh grid point.
//
// Input channel: in_valid / in_stall with nine signed Q2.14 coordinates
// (grid point, next along profile, next around rotation). A word is taken
// at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with normal_x/y/z (signed, FRAC_BITS
// fraction bits) and degenerate, set when the cross product is zero
// (components then read zero).
//
// Throughput: one word per cycle while out_stall does not hold the pipe. Stages:
// 4 front stages (cross product, magnitudes, squares, sum) + one cell per root
// bit (34) + one cell per quotient bit (FRAC_BITS+1) + the output register; Q1.14 out.
// The whole pipe advances together; when the output register holds a word
// and out_stall is high, every stage freezes and in_stall is raised, so
// no word is lost or repeated. Reset clears all valid bits; the pipe is
// empty and ready once reset is released.
module grid_surface_normal
    import gsn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  base_x,
    input  logic signed [IN_W-1:0]  base_y,
    input  logic signed [IN_W-1:0]  base_z,
    input  logic signed [IN_W-1:0]  row_next_x,
    input  logic signed [IN_W-1:0]  row_next_y,
    input  logic signed [IN_W-1:0]  row_next_z,
    input  logic signed [IN_W-1:0]  col_next_x,
    input  logic signed [IN_W-1:0]  col_next_y,
    input  logic signed [IN_W-1:0]  col_next_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] normal_x,
    output logic signed [OUT_W-1:0] normal_y,
    output logic signed [OUT_W-1:0] normal_z,
    output logic                    degenerate
);

    logic       en;
    logic       sq_valid [ROOT_W+1];
    sqrt_word_t sq_word  [ROOT_W+1];
    logic       dv_valid [Q_W+1];
    div_word_t  dv_word  [Q_W+1];
    div_word_t  dv_seed;

    logic [LANES-1:0][OUT_W-1:0] comp_next;
    logic [31:0]                 qz;
    logic                        out_valid_reg;
    logic [LANES-1:0][OUT_W-1:0] comp_reg;
    logic                        degen_reg;

    // pipe moves unless the output word is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    gsn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .base_x     (base_x),
        .base_y     (base_y),
        .base_z     (base_z),
        .row_next_x (row_next_x),
        .row_next_y (row_next_y),
        .row_next_z (row_next_z),
        .col_next_x (col_next_x),
        .col_next_y (col_next_y),
        .col_next_z (col_next_z),
        .out_valid  (sq_valid[0]),
        .out_word   (sq_word[0])
    );

    // floor square root, one root bit per cell
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        gsn_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_word   (sq_word[i]),
            .out_valid (sq_valid[i+1]),
            .out_word  (sq_word[i+1])
        );
    end

    // divider seed: |N| << FRAC_BITS, top part already below the length
    always_comb
    begin
        dv_seed       = '0;
        dv_seed.len   = sq_word[ROOT_W].root;
        dv_seed.neg   = sq_word[ROOT_W].neg;
        dv_seed.degen = sq_word[ROOT_W].degen;
        for (int k = 0; k < LANES; k++)
        begin
            dv_seed.rem[k] = {1'b0, sq_word[ROOT_W].mag[k][MAG_W-1:1]};
            dv_seed.low[k] = {sq_word[ROOT_W].mag[k][0], {(Q_W-1){1'b0}}};
        end
    end

    assign dv_valid[0] = sq_valid[ROOT_W];
    assign dv_word[0]  = dv_seed;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        gsn_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[i]),
            .in_word   (dv_word[i]),
            .out_valid (dv_valid[i+1]),
            .out_word  (dv_word[i+1])
        );
    end

    // sign, saturation and degenerate zeroing
    always_comb
    begin
        qz = '0;
        for (int k = 0; k < LANES; k++)
        begin
            qz = 32'(dv_word[Q_W].quo[k]);
            if (dv_word[Q_W].degen)
                comp_next[k] = '0;
            else if (dv_word[Q_W].neg[k])
                comp_next[k] = (qz > OUT_NEG_MAX) ? OUT_W'(OUT_NEG_MAX)
                                                  : OUT_W'(32'd0 - qz);
            else
                comp_next[k] = (qz > OUT_POS_MAX) ? OUT_W'(OUT_POS_MAX) : OUT_W'(qz);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_reg  <= comp_next;
            degen_reg <= dv_word[Q_W].degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = comp_reg[0];
    assign normal_y   = comp_reg[1];
    assign normal_z   = comp_reg[2];
    assign degenerate = degen_reg;

    // zero cross product gives zero components
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate word with nonzero normal");

    // a nonzero normal never normalizes to all zeros
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> !(normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("nonzero normal collapsed to zero");

    // held output freezes the pipe and back-pressures the input
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(comp_reg) && $stable(degen_reg))
        else $error("held output word changed");

endmodule
